// File: sv/cdfm_pkg.sv
// Package for the CDF histogram-matching lookup unit.
// Shared types, codes and default sizes; no dependencies.
package cdfm_pkg;

	localparam int LEVELS_DEF    = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LEVEL_W       = 8;
	localparam int VALUE_W       = 16;

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SRC,
		ST_SCAN,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [LEVEL_W-1:0] level;
		logic [VALUE_W-1:0] cdf_value;
	} in_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] mapped_level;
		logic               found;
	} out_word_t;

	typedef logic cfg_word_t;

	// compare unit status
	typedef struct packed {
		logic bracket;
		logic upper;
	} cmp_res_t;

endpackage

// File: sv/cdfm_chan_if.sv
// Valid/ready channel carrying one payload word.
// Payload type is a parameter; no other dependencies.
interface cdfm_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cdfm_table_mem.sv
// One CDF table: single write port, single read port, registered read data.
// Depends on nothing but its parameters.
module cdfm_table_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: sv/cdfm_pair_cmp.sv
// Shared bracket compare: tests lo <= v <= hi and picks the nearer end.
// Uses cdfm_pkg for the status struct.
module cdfm_pair_cmp import cdfm_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  logic [WIDTH-1:0] lo,
	input  logic [WIDTH-1:0] hi,
	input  logic [WIDTH-1:0] v,
	output cmp_res_t         res
);
	logic [WIDTH-1:0] d_lo;
	logic [WIDTH-1:0] d_hi;

	assign d_lo        = v - lo;
	assign d_hi        = hi - v;
	assign res.bracket = (lo <= v) && (hi >= v);
	// tie goes to the lower index
	assign res.upper   = d_lo > d_hi;
endmodule

// File: sv/cdf_histogram_match_lut_unit.sv
// Top level of the CDF histogram-matching lookup unit.
// Depends on cdfm_pkg, cdfm_chan_if, cdfm_table_mem and cdfm_pair_cmp.
//
// Usage:
//   req (sink)  : one word = {mode, level, cdf_value}. Mode LOAD_A / LOAD_B
//                 writes one entry of table A / B; mode QUERY maps a level.
//                 An unused mode code is dropped without effect.
//   rsp (source): one word {mapped_level, found} per query, none per load.
//   cfg (sink)  : one-bit map_direction; 0 maps A into B, 1 maps B into A.
//                 Always ready; write only while the unit is idle.
// Flow:
//   A load writes its entry; req stays ready.
//   A query holds req not-ready while one compare unit walks the target
//   table, one adjacent pair per cycle out of the table's read port: the
//   source entry is read, the pairs are compared in order from index 0,
//   then the result is posted once the output register is free. A level
//   beyond the table skips the read and the walk. req reopens in the same
//   cycle that rsp goes valid, so no new word is taken while a query runs.
// Reset clears the sequencer, output valid and map_direction; table
// contents are undefined until loaded. If rsp stalls, the finished result
// waits in the output register while the unit takes new words; a second
// query result waits in the sequencer until the register frees.
module cdf_histogram_match_lut_unit import cdfm_pkg::*; #(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cdfm_chan_if.sink   req,
	cdfm_chan_if.source rsp,
	cdfm_chan_if.sink   cfg
);
	localparam int AW = $clog2(LEVELS);

	seq_state_t state_q, state_d;

	logic                 dir_q;
	logic [AW-1:0]        cnt_q;
	logic [FRAC_BITS-1:0] v_q;
	logic [FRAC_BITS-1:0] lo_q;
	logic [LEVEL_W-1:0]   res_idx_q;
	logic                 res_hit_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic                 acc;
	logic                 lvl_ok;
	logic [AW-1:0]        lvl_idx;
	logic [FRAC_BITS-1:0] wval;
	logic                 we_a, we_b;
	logic [AW-1:0]        raddr_a, raddr_b;
	logic [FRAC_BITS-1:0] rdata_a, rdata_b;
	logic [FRAC_BITS-1:0] src_rdata, tgt_rdata;
	logic [AW-1:0]        cnt_inc;
	logic                 slot_free;
	cmp_res_t             cmp;

	// sequencer strobes
	logic                 go_query;
	logic                 take_src;
	logic                 step;
	logic                 set_res;
	logic                 res_hit_d;
	logic [LEVEL_W-1:0]   res_idx_d;
	logic                 post;

	// ---- input decode ----
	assign acc     = req.valid && req.ready;
	assign lvl_ok  = 32'(req.data.level) < LEVELS;
	assign lvl_idx = AW'(req.data.level);
	assign wval    = FRAC_BITS'(req.data.cdf_value);
	assign we_a    = acc && (req.data.mode == MODE_LOAD_A) && lvl_ok;
	assign we_b    = acc && (req.data.mode == MODE_LOAD_B) && lvl_ok;

	// ---- table reads ----
	// Idle: source table reads the query level, target table reads entry 0.
	// Scanning: target reads the entry after the current hi index.
	assign cnt_inc = cnt_q + AW'(1);
	assign raddr_a = (state_q == ST_IDLE) ? (dir_q ? '0 : lvl_idx) : cnt_inc;
	assign raddr_b = (state_q == ST_IDLE) ? (dir_q ? lvl_idx : '0) : cnt_inc;

	cdfm_table_mem #(.DEPTH(LEVELS), .WIDTH(FRAC_BITS)) u_tab_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (lvl_idx),
		.wdata (wval),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	cdfm_table_mem #(.DEPTH(LEVELS), .WIDTH(FRAC_BITS)) u_tab_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (lvl_idx),
		.wdata (wval),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign src_rdata = dir_q ? rdata_b : rdata_a;
	assign tgt_rdata = dir_q ? rdata_a : rdata_b;

	// lo_q = t[cnt_q-1], tgt_rdata = t[cnt_q] during the scan
	cdfm_pair_cmp #(.WIDTH(FRAC_BITS)) u_cmp (
		.lo  (lo_q),
		.hi  (tgt_rdata),
		.v   (v_q),
		.res (cmp)
	);

	assign slot_free = !out_valid_q || rsp.ready;

	// ---- sequencer ----
	always_comb begin
		state_d   = state_q;
		go_query  = 1'b0;
		take_src  = 1'b0;
		step      = 1'b0;
		set_res   = 1'b0;
		res_hit_d = 1'b0;
		res_idx_d = '0;
		post      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (req.data.mode == MODE_QUERY)) begin
					if (lvl_ok) begin
						go_query = 1'b1;
						state_d  = ST_SRC;
					end else begin
						set_res = 1'b1;
						state_d = ST_FIN;
					end
				end
			end
			ST_SRC: begin
				take_src = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (cmp.bracket) begin
					set_res   = 1'b1;
					res_hit_d = 1'b1;
					res_idx_d = cmp.upper ? LEVEL_W'(cnt_q) : LEVEL_W'(cnt_q - AW'(1));
					state_d   = ST_FIN;
				end else if (cnt_q == AW'(LEVELS - 1)) begin
					set_res = 1'b1;
					state_d = ST_FIN;
				end else begin
					step = 1'b1;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					post    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (go_query) begin
			cnt_q <= '0;
		end else if (take_src || step) begin
			cnt_q <= cnt_inc;
		end
		if (take_src) begin
			v_q  <= src_rdata;
			lo_q <= tgt_rdata;
		end else if (step) begin
			lo_q <= tgt_rdata;
		end
		if (set_res) begin
			res_hit_q <= res_hit_d;
			res_idx_q <= res_idx_d;
		end
		if (post) begin
			out_q.mapped_level <= res_idx_q;
			out_q.found        <= res_hit_q;
		end
	end

	// ---- output register and config ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dir_q       <= 1'b0;
		end else begin
			out_valid_q <= post || (out_valid_q && !rsp.ready);
			if (cfg.valid && cfg.ready) begin
				dir_q <= cfg.data;
			end
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign cfg.ready = 1'b1;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for cdf_histogram_match_lut_unit: loads both CDF tables,
// maps levels in both directions and checks every answer word. Needs cdfm_pkg and cdfm_chan_if.
module testbench;
	import cdfm_pkg::*;

	localparam int LEVELS       = LEVELS_DEF;
	localparam int FRAC_MAX     = (1 << FRAC_BITS_DEF) - 1;
	// Mode code the unit must drop without effect
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// map_direction settings
	localparam logic DIR_A_TO_B = 1'b0;
	localparam logic DIR_B_TO_A = 1'b1;
	// Worst query: source read, the full pair walk, result post, plus margin
	localparam int SCAN_LATENCY = LEVELS + 4;
	// Long receiver hold-off; outlasts two full scans so req backs up
	localparam int HOLD_CYCLES  = 3 * (LEVELS + 2) + 100;
	localparam int LIMIT_CYCLES = 2000000;
	// Counted random words per phase, table reload excluded
	localparam int PHASE_ITEMS  = 70;

	typedef enum int {
		SHAPE_RAMP,
		SHAPE_STEPS,
		SHAPE_NOISE,
		SHAPE_EXTREME
	} shape_t;

	logic clk;
	logic arst_n;

	cdfm_chan_if #(.payload_t(in_word_t))  req_if ();
	cdfm_chan_if #(.payload_t(out_word_t)) rsp_if ();
	cdfm_chan_if #(.payload_t(cfg_word_t)) cfg_if ();

	cdf_histogram_match_lut_unit #(
		.LEVELS(LEVELS),
		.FRAC_BITS(FRAC_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// Local copy of the unit's state, updated as words are accepted
	logic [VALUE_W-1:0] cdf_a [LEVELS];
	logic [VALUE_W-1:0] cdf_b [LEVELS];
	logic               map_dir = DIR_A_TO_B;

	in_word_t  word_q[$];          // words waiting to be offered on req
	out_word_t map_expect_q[$];    // predicted answers, oldest first

	in_word_t  took_w;
	out_word_t got_w;
	out_word_t exp_w;

	int words_pushed    = 0;
	int words_taken     = 0;
	int loads_taken     = 0;
	int queries_taken   = 0;
	int unused_taken    = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int err_count       = 0;
	int cycle_count     = 0;

	int burst_left = 0;
	int gap_left   = 0;
	int hold_left  = 0;
	int rsp_taken  = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	logic [5:0]  pat_age   = '0;

	// Clock, plus known values on every input before the first edge
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		rsp_if.ready  = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = DIR_A_TO_B;
		forever #6 clk = ~clk;
	end

	// Map one level the way the unit should: read the source entry, then walk
	// the target from index 0 for the first pair with t[i] <= v <= t[i+1].
	// Nearer index wins, ties go low; no bracket gives found = 0, level 0.
	function automatic out_word_t predict_mapping(input logic [LEVEL_W-1:0] lvl);
		out_word_t          r;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] lo;
		logic [VALUE_W-1:0] hi;
		r = '0;
		v = (map_dir == DIR_B_TO_A) ? cdf_b[lvl] : cdf_a[lvl];
		for (int i = 0; i < LEVELS - 1; i++) begin
			lo = (map_dir == DIR_B_TO_A) ? cdf_a[i] : cdf_b[i];
			hi = (map_dir == DIR_B_TO_A) ? cdf_a[i + 1] : cdf_b[i + 1];
			if (lo <= v && v <= hi) begin
				r.found        = 1'b1;
				r.mapped_level = ((v - lo) <= (hi - v)) ? LEVEL_W'(i) : LEVEL_W'(i + 1);
				return r;
			end
		end
		return r;
	endfunction

	task automatic push_word(input logic [1:0] m, input int lvl, input int val);
		in_word_t w;
		w.mode      = m;
		w.level     = LEVEL_W'(lvl);
		w.cdf_value = VALUE_W'(val);
		word_q.push_back(w);
		words_pushed++;
	endtask

	// Rewrite a whole table with one curve shape. Ramps and steps are
	// monotone (steps give flat runs, so equal neighbors and ties); noise
	// is not, so many queries miss; extreme is a hard 0 -> full-scale jump.
	task automatic reload_table(input logic [1:0] tbl, input shape_t shape);
		int acc;
		int val;
		acc = 0;
		for (int i = 0; i < LEVELS; i++) begin
			case (shape)
				SHAPE_RAMP: begin
					acc = acc + $urandom_range(0, 512);
					if (acc > FRAC_MAX) acc = FRAC_MAX;
					val = acc;
				end
				SHAPE_STEPS: begin
					if ($urandom_range(0, 7) == 0) acc = acc + $urandom_range(1, 4096);
					if (acc > FRAC_MAX) acc = FRAC_MAX;
					val = acc;
				end
				SHAPE_NOISE: begin
					val = $urandom_range(0, FRAC_MAX);
				end
				default: begin
					val = (i < LEVELS / 2) ? 0 : FRAC_MAX;
				end
			endcase
			push_word(tbl, i, val);
		end
	endtask

	// Idle means every pushed word taken and every answer back; loads give
	// no answer, so allow one more full scan before touching the register.
	task automatic wait_drained();
		do @(posedge clk); while (words_taken != words_pushed || map_expect_q.size() != 0);
		repeat (SCAN_LATENCY) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		cfg_if.data  <= d;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// Driver: offers queued words in bursts with random gaps; a word stays
	// put until taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (gap_left > 0) begin
				gap_left     <= gap_left - 1;
				req_if.valid <= 1'b0;
			end else if (word_q.size() > 0) begin
				req_if.data  <= word_q.pop_front();
				req_if.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready follows a rotating 16-bit pattern, reloaded each time
	// the 6-bit age counter wraps (always ready, random, mostly ready or mostly
	// stalled), and is forced low during a hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= (hold_left > 0) ? 1'b0 : stall_pat[0];
			pat_age      <= pat_age + 1'b1;
			if (pat_age == '1) begin
				case ($urandom_range(0, 3))
					0:       stall_pat <= '1;
					1:       stall_pat <= 16'($urandom);
					2:       stall_pat <= 16'($urandom | $urandom);
					default: stall_pat <= 16'($urandom & $urandom);
				endcase
			end else begin
				stall_pat <= {stall_pat[0], stall_pat[15:1]};
			end
		end
	end

	// Hold-off counter: after the 30th and 120th answer the receiver stops
	// for a long stretch; the output register and sequencer fill and req
	// must back off while the driver keeps offering words.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			rsp_taken <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) rsp_taken <= rsp_taken + 1;
			if (rsp_if.valid && rsp_if.ready && (rsp_taken == 29 || rsp_taken == 119)) begin
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// Monitor and predictor in one process: check the answer word first,
	// then apply a register write, then the accepted req word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got_w = rsp_if.data;
				if (map_expect_q.size() == 0) begin
					$error("unexpected answer word: mapped_level %0d found %0d",
						got_w.mapped_level, got_w.found);
					err_count++;
				end else begin
					exp_w = map_expect_q.pop_front();
					if (got_w.mapped_level !== exp_w.mapped_level) begin
						$error("mapped_level: expected %0d, got %0d",
							exp_w.mapped_level, got_w.mapped_level);
						err_count++;
					end
					if (got_w.found !== exp_w.found) begin
						$error("found: expected %0d, got %0d", exp_w.found, got_w.found);
						err_count++;
					end
					results_checked++;
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				map_dir = cfg_if.data;
				cfg_writes++;
			end
			if (req_if.valid && req_if.ready) begin
				took_w = req_if.data;
				case (took_w.mode)
					MODE_LOAD_A: begin
						cdf_a[took_w.level] = took_w.cdf_value;
						loads_taken++;
					end
					MODE_LOAD_B: begin
						cdf_b[took_w.level] = took_w.cdf_value;
						loads_taken++;
					end
					MODE_QUERY: begin
						map_expect_q.push_back(predict_mapping(took_w.level));
						queries_taken++;
					end
					default: begin
						unused_taken++;
					end
				endcase
				// count last, so an idle check never sees a taken query
				// without its prediction queued
				words_taken++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d answers outstanding",
				cycle_count, map_expect_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int     counted;
		int     pick;
		logic   dir;
		shape_t shapes [4];
		shapes = '{SHAPE_STEPS, SHAPE_RAMP, SHAPE_NOISE, SHAPE_EXTREME};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both tables completely, so no query ever reads an unwritten
		// entry: A[i] = 257*i reaches full scale, B[i] = 256*i stops short.
		for (int i = 0; i < LEVELS; i++) push_word(MODE_LOAD_A, i, 257 * i);
		for (int i = 0; i < LEVELS; i++) push_word(MODE_LOAD_B, i, 256 * i);

		// Directed words, direction A into B (reset value)
		push_word(MODE_QUERY, 0, 0);              // v = 0 on the first pair's low end
		push_word(MODE_QUERY, 255, FRAC_MAX);     // full scale above all of B: miss
		push_word(MODE_LOAD_B, 1, 100);
		push_word(MODE_LOAD_A, 7, 50);
		push_word(MODE_QUERY, 7, 0);              // exact midpoint: tie goes low
		push_word(MODE_LOAD_A, 7, 51);
		push_word(MODE_QUERY, 7, FRAC_MAX);       // one past midpoint: upper index
		push_word(MODE_LOAD_A, 9, 100);
		push_word(MODE_QUERY, 9, 0);              // v on the pair's high end
		push_word(MODE_LOAD_B, 255, FRAC_MAX);
		push_word(MODE_QUERY, 255, 0);            // top index answered
		push_word(MODE_UNUSED, 255, 0);           // dropped, must not touch B[255]
		push_word(MODE_QUERY, 255, 0);
		push_word(MODE_UNUSED, 0, FRAC_MAX);
		push_word(MODE_LOAD_B, 128, 0);           // dip in the target
		push_word(MODE_QUERY, 200, 0);
		push_word(MODE_LOAD_A, 3, FRAC_MAX);
		push_word(MODE_QUERY, 3, 0);
		wait_drained();

		// Random phases, direction flipping each time; one table gets a new
		// curve per phase, then a mix of queries, point loads and junk words.
		for (int phase = 0; phase < 4; phase++) begin
			dir = (phase % 2 == 0) ? DIR_B_TO_A : DIR_A_TO_B;
			write_direction(dir);
			reload_table((phase % 2 == 0) ? MODE_LOAD_A : MODE_LOAD_B, shapes[phase]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					if ($urandom_range(0, 9) == 0) begin
						push_word(MODE_QUERY, ($urandom_range(0, 1) == 0) ? 0 : LEVELS - 1,
							$urandom_range(0, FRAC_MAX));
					end else begin
						push_word(MODE_QUERY, $urandom_range(0, LEVELS - 1),
							$urandom_range(0, FRAC_MAX));
					end
					counted++;
				end else if (pick < 95) begin
					push_word(($urandom_range(0, 1) == 0) ? MODE_LOAD_A : MODE_LOAD_B,
						$urandom_range(0, LEVELS - 1),
						($urandom_range(0, 3) == 0) ?
							(($urandom_range(0, 1) == 0) ? 0 : FRAC_MAX) :
							$urandom_range(0, FRAC_MAX));
					counted++;
				end else begin
					// ignored by the unit, not counted
					push_word(MODE_UNUSED, $urandom_range(0, LEVELS - 1),
						$urandom_range(0, FRAC_MAX));
				end
			end
			wait_drained();
		end

		$display("Took %0d words: %0d table loads, %0d level queries, %0d unused-mode words",
			words_taken, loads_taken, queries_taken, unused_taken);
		$display("Checked %0d answer words over %0d direction writes; %0d mismatches",
			results_checked, cfg_writes, err_count);
		if (err_count == 0 && map_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
